// File: design/targa_pixel_decoder_top_assert.svh
// Assertion macros shared by the checker.
// Both sample on posedge clk and are switched off while arst_n is low.
`ifndef TARGA_PIXEL_DECODER_TOP_ASSERT_SVH
`define TARGA_PIXEL_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define TPD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tpd check failed");

// Next-cycle implication.
`define TPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tpd check failed");

`endif

// File: design/tpd_pkg.sv
`timescale 1ns / 1ps

package tpd_pkg;

	localparam int PIXEL_COUNT_BITS_DEF = 32;
	localparam int CFG_DATA_BITS        = 32;
	localparam int CFG_INDEX_BITS       = 1;
	localparam int Q_DEPTH              = 2;

	// format_mode codes
	localparam logic [2:0] MODE_RAW24 = 3'd0;
	localparam logic [2:0] MODE_RAW32 = 3'd1;
	localparam logic [2:0] MODE_RAW16 = 3'd2;
	localparam logic [2:0] MODE_RLE24 = 3'd3;
	localparam logic [2:0] MODE_RLE32 = 3'd4;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_FORMAT_MODE = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PIXEL_TOTAL = 1'b1;

	localparam logic [7:0] RLE_RUN_FLAG = 8'd128;
	localparam logic [7:0] RLE_RUN_BIAS = 8'd127;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

	typedef enum logic [1:0] {
		KIND_RGB24,
		KIND_RGBA32,
		KIND_RGB16
	} pix_kind_t;

	// One finished pixel as the front hands it on: bytes in file order.
	typedef struct packed {
		pix_kind_t  kind;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [7:0] count;
		logic       last;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_push_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_head_t;

endpackage

// File: design/targa_pixel_decoder_top.sv
// Path: a byte that completes a pixel is written into the queue at the edge that takes it,
// then loaded into the output register once that register is empty or being drained.
// Throughput: one byte per cycle; in_ready drops only once the two-word queue and the
// output register are all full. A pixel is 2, 3 or 4 bytes plus one header per RLE packet.
// Reset (arst_n low, asynchronous): control state, queue and config registers clear
// (format_mode raw 24 bit, pixel_total zero); byte buffer and payload are not reset.
`timescale 1ns / 1ps

module targa_pixel_decoder_top #(
	// width of the pixel counter; pixel_total bits above it are ignored
	parameter int PIXEL_COUNT_BITS = tpd_pkg::PIXEL_COUNT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// config write port: index 0 format_mode, index 1 pixel_total
	input  logic                               cfg_we,
	input  logic [tpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [tpd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	// byte stream in
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         data_byte,
	input  logic                               image_start,
	// pixel words out
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [7:0]                         red,
	output logic [7:0]                         green,
	output logic [7:0]                         blue,
	output logic [7:0]                         alpha,
	output logic [7:0]                         repeat_count,
	output logic                               image_last
);

	tpd_pkg::q_push_t push;
	tpd_pkg::q_head_t head;
	logic             q_full;
	logic             pop;

	// Front: parses packet headers, collects pixel bytes, counts pixels and
	// clips runs. All per-byte state lives here and updates at the edge that takes a byte.
	tpd_front #(
		.PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.data_byte   (data_byte),
		.image_start (image_start),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.q_full      (q_full),
		.push        (push)
	);

	// Two-entry queue of finished pixels; lets the front keep taking bytes
	// while a word waits at the output.
	tpd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	// Back: channel reorder / 16 bit expansion into the output register.
	tpd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.repeat_count (repeat_count),
		.image_last   (image_last)
	);

endmodule

// File: design/tpd_front.sv
`timescale 1ns / 1ps

module tpd_front #(
	parameter int PIXEL_COUNT_BITS = tpd_pkg::PIXEL_COUNT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [tpd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [tpd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic [7:0]                           data_byte,
	input  logic                                 image_start,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 q_full,
	output tpd_pkg::q_push_t                     push
);

	logic [2:0]                  format_mode_q;
	logic [PIXEL_COUNT_BITS-1:0] pixel_total_q;
	logic [1:0]                  phase_q;
	logic [7:0]                  packet_left_q;
	logic                        is_run_q;
	logic [PIXEL_COUNT_BITS-1:0] pixels_left_q;
	logic [7:0]                  held_q [3];

	logic                        take;
	logic [1:0]                  phase_e;
	logic [7:0]                  pl_e;
	logic                        run_e;
	logic [PIXEL_COUNT_BITS-1:0] left_e;
	logic                        is_rle;
	logic [1:0]                  last_phase;
	logic                        active;
	logic                        header;
	logic                        stash;
	logic                        complete;
	logic [7:0]                  count;
	logic [1:0]                  phase_d;
	logic [7:0]                  pl_d;
	logic                        run_d;
	logic [PIXEL_COUNT_BITS-1:0] left_d;
	tpd_pkg::pix_kind_t          kind;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;

	always_comb begin
		// start byte restarts the image before it is looked at
		phase_e = image_start ? 2'd0 : phase_q;
		pl_e    = image_start ? 8'd0 : packet_left_q;
		run_e   = image_start ? 1'b0 : is_run_q;
		left_e  = image_start ? pixel_total_q : pixels_left_q;

		is_rle = (format_mode_q == tpd_pkg::MODE_RLE24) ||
			(format_mode_q == tpd_pkg::MODE_RLE32);

		unique case (format_mode_q) inside
			tpd_pkg::MODE_RAW32, tpd_pkg::MODE_RLE32: begin
				last_phase = 2'd3;
				kind       = tpd_pkg::KIND_RGBA32;
			end
			tpd_pkg::MODE_RAW16: begin
				last_phase = 2'd1;
				kind       = tpd_pkg::KIND_RGB16;
			end
			default: begin
				last_phase = 2'd2;
				kind       = tpd_pkg::KIND_RGB24;
			end
		endcase

		active   = (left_e != '0);
		header   = active && is_rle && (pl_e == 8'd0) && (phase_e == 2'd0);
		stash    = active && !header && (phase_e < last_phase);
		complete = active && !header && !stash;

		phase_d = phase_e;
		pl_d    = pl_e;
		run_d   = run_e;
		left_d  = left_e;
		count   = 8'd1;

		if (header) begin
			if (data_byte < tpd_pkg::RLE_RUN_FLAG) begin
				pl_d  = data_byte + 8'd1;
				run_d = 1'b0;
			end else begin
				pl_d  = data_byte - tpd_pkg::RLE_RUN_BIAS;
				run_d = 1'b1;
			end
		end else if (stash) begin
			phase_d = phase_e + 2'd1;
		end else if (complete) begin
			phase_d = 2'd0;
			if (is_rle && run_e) begin
				// clip the run to what is left of the image
				if (left_e < PIXEL_COUNT_BITS'(pl_e))
					count = left_e[7:0];
				else
					count = pl_e;
				pl_d = 8'd0;
			end else if (is_rle) begin
				pl_d = pl_e - 8'd1;
			end
			left_d = left_e - PIXEL_COUNT_BITS'(count);
		end
	end

	always_comb begin
		push.valid       = take && complete;
		push.entry.kind  = kind;
		push.entry.b0    = held_q[0];
		push.entry.b1    = held_q[1];
		push.entry.b2    = held_q[2];
		push.entry.b3    = data_byte;
		push.entry.count = count;
		push.entry.last  = (left_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_mode_q <= tpd_pkg::MODE_RAW24;
			pixel_total_q <= '0;
			phase_q       <= 2'd0;
			packet_left_q <= 8'd0;
			is_run_q      <= 1'b0;
			pixels_left_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tpd_pkg::CFG_FORMAT_MODE: format_mode_q <= cfg_data[2:0];
					tpd_pkg::CFG_PIXEL_TOTAL:
						pixel_total_q <= cfg_data[PIXEL_COUNT_BITS-1:0];
					default: ;
				endcase
			end
			if (take) begin
				phase_q       <= phase_d;
				packet_left_q <= pl_d;
				is_run_q      <= run_d;
				pixels_left_q <= left_d;
			end
		end
	end

	// held bytes carry no reset
	always_ff @(posedge clk) begin
		if (take && stash)
			held_q[phase_e] <= data_byte;
	end

endmodule

// File: design/tpd_queue.sv
`timescale 1ns / 1ps

module tpd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  tpd_pkg::q_push_t  push,
	input  logic              pop,
	output logic              full,
	output tpd_pkg::q_head_t  head
);

	localparam int PTR_BITS = (tpd_pkg::Q_DEPTH > 1) ? $clog2(tpd_pkg::Q_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(tpd_pkg::Q_DEPTH + 1);
	localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(tpd_pkg::Q_DEPTH);
	localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(tpd_pkg::Q_DEPTH - 1);

	tpd_pkg::q_entry_t   mem_q [tpd_pkg::Q_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                do_push;
	logic                do_pop;

	assign full       = (cnt_q == CNT_FULL);
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && (cnt_q != '0);
	assign head.valid = (cnt_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push.entry;
	end

endmodule

// File: design/tpd_back.sv
`timescale 1ns / 1ps

module tpd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tpd_pkg::q_head_t head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [7:0]       alpha,
	output logic [7:0]       repeat_count,
	output logic             image_last
);

	logic        valid_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;
	logic [7:0]  alpha_q;
	logic [7:0]  count_q;
	logic        last_q;
	logic [15:0] word16;
	logic [7:0]  r_d;
	logic [7:0]  g_d;
	logic [7:0]  b_d;
	logic [7:0]  a_d;

	assign pop = head.valid && (!valid_q || out_ready);

	always_comb begin
		word16 = {head.entry.b3, head.entry.b0};
		unique case (head.entry.kind)
			tpd_pkg::KIND_RGB16: begin
				// 5-5-5 little endian, widened by a shift of 3
				b_d = {word16[4:0], 3'b000};
				g_d = {word16[9:5], 3'b000};
				r_d = {word16[14:10], 3'b000};
				a_d = tpd_pkg::ALPHA_OPAQUE;
			end
			tpd_pkg::KIND_RGBA32: begin
				b_d = head.entry.b0;
				g_d = head.entry.b1;
				r_d = head.entry.b2;
				a_d = head.entry.b3;
			end
			default: begin
				b_d = head.entry.b0;
				g_d = head.entry.b1;
				r_d = head.entry.b3;
				a_d = tpd_pkg::ALPHA_OPAQUE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			red_q   <= r_d;
			green_q <= g_d;
			blue_q  <= b_d;
			alpha_q <= a_d;
			count_q <= head.entry.count;
			last_q  <= head.entry.last;
		end
	end

	assign out_valid    = valid_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;
	assign alpha        = alpha_q;
	assign repeat_count = count_q;
	assign image_last   = last_q;

endmodule

// File: design/tpd_checker.sv
`timescale 1ns / 1ps
`include "targa_pixel_decoder_top_assert.svh"

module tpd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic [7:0] alpha,
	input logic [7:0] repeat_count,
	input logic       image_last
);

	// stalled word holds
	`TPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(red) && $stable(green) && $stable(blue) && $stable(alpha) && $stable(repeat_count) && $stable(image_last))

	// input backs up only behind a waiting output word
	`TPD_ASSERT_NOW(a_stall_needs_word, !in_ready, out_valid)

	// with the output drained every cycle, input never stalls
	`TPD_ASSERT_NOW(a_no_stall_when_drained, out_ready && $past(out_ready), in_ready)

	// empty pipe with no new byte stays empty
	`TPD_ASSERT_NEXT(a_no_phantom_word, (!out_valid && !(in_valid && in_ready)) ##1 !out_valid, !out_valid)

endmodule

bind targa_pixel_decoder_top tpd_checker u_tpd_checker (.*);

// File: tb/sv/targa_pixel_decoder_top_test.sv
`timescale 1ns / 1ps

module targa_pixel_decoder_top_test;
	import tpd_pkg::*;

	localparam int          HALF_PERIOD     = 6;
	localparam int          RESET_CYCLES    = 8;
	localparam int          RANDOM_WORDS    = 1425;
	localparam int          CALM_TAIL_WORDS = 200;
	// Output shows once the completing byte has passed the queue and the output register;
	// leave margin for bytes that produce nothing but may still be in flight.
	localparam int          SETTLE_CYCLES   = 5;
	localparam int          WATCHDOG_NS     = 3_600_000;
	localparam int          PIX_BITS        = PIXEL_COUNT_BITS_DEF;
	localparam logic [31:0] COUNT_MASK      = 32'((64'd1 << PIX_BITS) - 64'd1);
	localparam logic [31:0] PIXEL_TOTAL_MAX = 32'd4294836225;
	localparam logic [2:0]  MODE_UNDEF_LO   = 3'd5;
	localparam logic [2:0]  MODE_UNDEF_HI   = 3'd7;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] reps;
		logic       last;
	} pixel_t;

	// How a directed row is checked: by the predictor, as producing nothing,
	// or against the pixel typed into the row.
	typedef enum {CHK_MODEL, CHK_NONE, CHK_PIXEL} check_kind_t;
	typedef enum {ROW_CFG, ROW_BYTE} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [2:0]  mode;
		logic [31:0] total;
		logic [7:0]  b;
		logic        st;
		check_kind_t chk;
		pixel_t      px;
	} row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_FORMAT_MODE;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [7:0]                data_byte = 8'h00;
	logic                      image_start = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [7:0]                red;
	logic [7:0]                green;
	logic [7:0]                blue;
	logic [7:0]                alpha;
	logic [7:0]                repeat_count;
	logic                      image_last;

	targa_pixel_decoder_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.image_start  (image_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.repeat_count (repeat_count),
		.image_last   (image_last)
	);

	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------
	// Decoder predictor: its own copy of registers and packet state.
	// ------------------------------------------------------------------
	logic [2:0]  fmt_q      = MODE_RAW24;
	logic [31:0] total_q    = '0;
	logic [1:0]  phase_q    = '0;
	logic [7:0]  pkt_left_q = '0;   // 0: next byte is a packet header
	logic        pkt_run_q  = 1'b0;
	logic [31:0] left_q     = '0;   // pixels still owed to the image
	logic [7:0]  held_q [3] = '{8'h00, 8'h00, 8'h00};

	pixel_t pixels_due[$];          // expected pixel words, oldest first
	row_t   plan[$];                // directed stimulus table

	int  mismatches     = 0;
	int  words_sent     = 0;
	int  words_checked  = 0;
	int  runs_checked   = 0;
	int  images_started = 0;
	int  stall_left     = 0;
	bit  source_calm    = 1'b0;
	bit  sink_calm      = 1'b0;
	bit  tail           = 1'b0;

	function automatic int pixel_bytes(input logic [2:0] m);
		case (m)
			MODE_RAW32, MODE_RLE32: return 4;
			MODE_RAW16:             return 2;
			default:                return 3;
		endcase
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic st, output bit got,
			output pixel_t px);
		bit          rle;
		int          bpp;
		logic [15:0] w;
		logic [31:0] reps;
		got = 1'b0;
		px = '0;
		rle = (fmt_q == MODE_RLE24) || (fmt_q == MODE_RLE32);
		bpp = pixel_bytes(fmt_q);
		if (st) begin
			left_q = total_q & COUNT_MASK;
			phase_q = '0;
			pkt_left_q = '0;
			pkt_run_q = 1'b0;
		end
		// nothing owed: before any start, after the last pixel, empty image
		if (left_q == 0)
			return;
		if (rle && pkt_left_q == 0 && phase_q == 0) begin
			if (b < RLE_RUN_FLAG) begin
				pkt_left_q = b + 8'd1;
				pkt_run_q = 1'b0;
			end else begin
				pkt_left_q = b - RLE_RUN_BIAS;
				pkt_run_q = 1'b1;
			end
			return;
		end
		// a phase at or past the last byte completes the pixel, which also
		// covers a format switch in the middle of one
		if (int'(phase_q) + 1 < bpp) begin
			held_q[phase_q] = b;
			phase_q = phase_q + 2'd1;
			return;
		end
		px.alpha = ALPHA_OPAQUE;
		if (fmt_q == MODE_RAW16) begin
			w = {b, held_q[0]};
			px.blue  = {w[4:0], 3'b000};
			px.green = {w[9:5], 3'b000};
			px.red   = {w[14:10], 3'b000};
		end else if (bpp == 4) begin
			px.blue  = held_q[0];
			px.green = held_q[1];
			px.red   = held_q[2];
			px.alpha = b;
		end else begin
			px.blue  = held_q[0];
			px.green = held_q[1];
			px.red   = b;
		end
		phase_q = '0;
		reps = 32'd1;
		if (rle && pkt_run_q) begin
			// run clipped to what the image still needs
			reps = {24'd0, pkt_left_q};
			if (reps > left_q)
				reps = left_q;
			pkt_left_q = '0;
		end else if (rle) begin
			pkt_left_q = pkt_left_q - 8'd1;
		end
		left_q = left_q - reps;
		px.reps = reps[7:0];
		px.last = (left_q == 0);
		got = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Drivers. All inputs change by nonblocking assignment right after a
	// rising edge; handshakes are judged on pre-edge values.
	// ------------------------------------------------------------------

	// One input word; the prediction is queued at the accepting edge.
	task automatic send_byte(input logic [7:0] b, input logic st, input check_kind_t chk,
			input pixel_t given);
		bit     got;
		pixel_t px;
		in_valid <= 1'b1;
		data_byte <= b;
		image_start <= st;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		words_sent++;
		if (st)
			images_started++;
		decode_byte(b, st, got, px);
		case (chk)
			CHK_MODEL: if (got) pixels_due.push_back(px);
			CHK_PIXEL: pixels_due.push_back(given);
			default: ;
		endcase
		// keep valid high into the next word unless a gap is drawn
		if (!source_calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// Registers only change with nothing in flight.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input bit do_mode, input logic [2:0] m, input bit do_total,
			input logic [31:0] t);
		if (do_mode) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_FORMAT_MODE;
			cfg_data <= CFG_DATA_BITS'(m);
			fmt_q = m;
			@(posedge clk);
		end
		if (do_total) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_PIXEL_TOTAL;
			cfg_data <= t;
			total_q = t;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [2:0] pick_mode();
		if ($urandom_range(0, 9) == 0)
			return 3'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI));
		return 3'($urandom_range(MODE_RAW24, MODE_RLE32));
	endfunction

	// Byte inside a random image. Outside the calm tail it may first pause the
	// stream for a register change (often landing inside a pixel) or force a
	// restart of the image.
	task automatic feed_byte(input logic [7:0] b, inout bit first);
		logic st;
		st = first;
		first = 1'b0;
		if (!tail && $urandom_range(0, 99) == 0) begin
			wait_drained();
			if ($urandom_range(0, 1) == 0)
				write_regs(1'b1, pick_mode(), 1'b0, '0);
			else
				write_regs(1'b0, '0, 1'b1, 32'($urandom_range(1, 20)));
		end
		if (!tail && $urandom_range(0, 249) == 0)
			st = 1'b1;
		send_byte(b, st, CHK_MODEL, '0);
	endtask

	task automatic feed_pixel(input int bpp, inout bit first);
		repeat (bpp) feed_byte(8'($urandom_range(0, 255)), first);
	endtask

	// One image: mostly a well-formed byte stream for the chosen format with
	// random content; sometimes plain noise with random restarts.
	task automatic random_image(input bit noise);
		logic [2:0]  m;
		logic [31:0] tot;
		int          bpp;
		int          target;
		int          done;
		int          k;
		int          sel;
		bit          rle;
		bit          first;
		wait_drained();
		tail = (words_sent >= RANDOM_WORDS - CALM_TAIL_WORDS);
		source_calm = tail || ($urandom_range(0, 3) == 0);
		sink_calm = tail || ($urandom_range(0, 3) == 0);
		m = pick_mode();
		sel = $urandom_range(0, 19);
		case (sel)
			0:       tot = '0;
			1:       tot = '1;
			2:       tot = PIXEL_TOTAL_MAX;
			3:       tot = $urandom();
			4:       tot = 32'd1;
			default: tot = 32'($urandom_range(2, 24));
		endcase
		write_regs(1'b1, m, 1'b1, tot);
		bpp = pixel_bytes(m);
		rle = (m == MODE_RLE24) || (m == MODE_RLE32);
		target = (tot > 32'd30) ? 30 : int'(tot);
		first = 1'b1;
		if (noise) begin
			repeat ($urandom_range(20, 60))
				send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0),
					CHK_MODEL, '0);
			return;
		end
		if (target == 0)
			repeat ($urandom_range(1, 6)) feed_byte(8'($urandom_range(0, 255)), first);
		done = 0;
		while (done < target) begin
			if (!rle) begin
				feed_pixel(bpp, first);
				done++;
			end else if ($urandom_range(0, 1) == 0) begin
				// run packet, now and then long enough to overrun the image
				k = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
				feed_byte(8'(k) + RLE_RUN_BIAS, first);
				feed_pixel(bpp, first);
				done += k;
			end else begin
				// raw packet; the longest header is cut short by the image end
				k = ($urandom_range(0, 15) == 0) ? 128 : $urandom_range(1, 6);
				feed_byte(8'(k - 1), first);
				for (int i = 0; i < k && done < target; i++) begin
					feed_pixel(bpp, first);
					done++;
				end
			end
		end
		// bytes past the last pixel are dropped by the block
		repeat ($urandom_range(0, 3)) feed_byte(8'($urandom_range(0, 255)), first);
	endtask

	// ------------------------------------------------------------------
	// Directed table helpers.
	// ------------------------------------------------------------------
	function automatic void plan_cfg(input logic [2:0] m, input logic [31:0] t);
		row_t r;
		r.kind = ROW_CFG;
		r.mode = m;
		r.total = t;
		r.b = '0;
		r.st = 1'b0;
		r.chk = CHK_NONE;
		r.px = '0;
		plan.push_back(r);
	endfunction

	function automatic void plan_byte(input logic [7:0] b, input logic st,
			input check_kind_t chk);
		row_t r;
		r.kind = ROW_BYTE;
		r.mode = '0;
		r.total = '0;
		r.b = b;
		r.st = st;
		r.chk = chk;
		r.px = '0;
		plan.push_back(r);
	endfunction

	function automatic void plan_pixel(input logic [7:0] b, input logic st,
			input logic [7:0] r8, input logic [7:0] g8, input logic [7:0] b8,
			input logic [7:0] a8, input logic [7:0] n8, input logic last);
		row_t r;
		r.kind = ROW_BYTE;
		r.mode = '0;
		r.total = '0;
		r.b = b;
		r.st = st;
		r.chk = CHK_PIXEL;
		r.px = '{red: r8, green: g8, blue: b8, alpha: a8, reps: n8, last: last};
		plan.push_back(r);
	endfunction

	// ------------------------------------------------------------------
	// Output side: random ready stalls in bursts, none while calm.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!sink_calm && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 9) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatches++;
		end
	endtask

	// Every accepted pixel word is matched against the oldest expectation.
	always @(posedge clk) begin : scoreboard
		pixel_t want;
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (pixels_due.size() == 0) begin
				$error("pixel word with nothing expected: r=%0h g=%0h b=%0h a=%0h n=%0d",
					red, green, blue, alpha, repeat_count);
				mismatches++;
			end else begin
				want = pixels_due.pop_front();
				check_field("red", want.red, red);
				check_field("green", want.green, green);
				check_field("blue", want.blue, blue);
				check_field("alpha", want.alpha, alpha);
				check_field("repeat_count", want.reps, repeat_count);
				check_field("image_last", 8'(want.last), 8'(image_last));
				words_checked++;
				if (want.reps > 8'd1)
					runs_checked++;
			end
		end
	end

	initial begin
		#WATCHDOG_NS;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		// Directed table. Typed pixels are the ones readable straight from the
		// byte layout; the bytes leading up to them go through the predictor.
		plan_byte(8'h5a, 1'b0, CHK_NONE);       // no image started yet
		plan_byte(8'hff, 1'b1, CHK_NONE);       // start with pixel_total still zero
		plan_cfg(MODE_UNDEF_HI, 32'd1);         // unused code behaves as raw 24
		plan_byte(8'h00, 1'b1, CHK_MODEL);
		plan_byte(8'h80, 1'b0, CHK_MODEL);
		plan_pixel(8'hff, 1'b0, 8'hff, 8'h80, 8'h00, ALPHA_OPAQUE, 8'd1, 1'b1);
		plan_byte(8'h33, 1'b0, CHK_NONE);       // past the last pixel
		plan_cfg(MODE_RAW32, 32'd1);
		plan_byte(8'h01, 1'b1, CHK_MODEL);
		plan_byte(8'h02, 1'b0, CHK_MODEL);
		plan_byte(8'h03, 1'b0, CHK_MODEL);
		plan_pixel(8'h04, 1'b0, 8'h03, 8'h02, 8'h01, 8'h04, 8'd1, 1'b1);
		plan_cfg(MODE_RAW16, 32'd1);
		plan_byte(8'hff, 1'b1, CHK_MODEL);      // 0x7fff: every channel at full scale
		plan_pixel(8'h7f, 1'b0, 8'hf8, 8'hf8, 8'hf8, ALPHA_OPAQUE, 8'd1, 1'b1);
		plan_cfg(MODE_RLE24, 32'd3);
		plan_byte(8'h81, 1'b1, CHK_NONE);       // run of two
		plan_byte(8'h10, 1'b0, CHK_MODEL);
		plan_byte(8'h20, 1'b0, CHK_MODEL);
		plan_pixel(8'h30, 1'b0, 8'h30, 8'h20, 8'h10, ALPHA_OPAQUE, 8'd2, 1'b0);
		plan_byte(8'hff, 1'b0, CHK_NONE);       // run of 128, one pixel left
		plan_byte(8'h40, 1'b0, CHK_MODEL);
		plan_byte(8'h50, 1'b0, CHK_MODEL);
		plan_pixel(8'h60, 1'b0, 8'h60, 8'h50, 8'h40, ALPHA_OPAQUE, 8'd1, 1'b1);
		plan_cfg(MODE_RLE32, 32'd1);
		plan_byte(8'h00, 1'b1, CHK_NONE);       // raw packet of one
		plan_byte(8'ha1, 1'b0, CHK_MODEL);
		plan_byte(8'hb2, 1'b0, CHK_MODEL);
		plan_byte(8'hc3, 1'b0, CHK_MODEL);
		plan_pixel(8'hd4, 1'b0, 8'hc3, 8'hb2, 8'ha1, 8'hd4, 8'd1, 1'b1);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				wait_drained();
				write_regs(1'b1, plan[i].mode, 1'b1, plan[i].total);
			end else begin
				send_byte(plan[i].b, plan[i].st, plan[i].chk, plan[i].px);
			end
		end

		// Random images until the word budget is spent; the last stretch
		// runs with both sides streaming flat out.
		while (words_sent < plan.size() + RANDOM_WORDS)
			random_image($urandom_range(0, 7) == 0);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d input words over %0d image starts in every format.",
			words_sent, images_started);
		$display("Checked %0d pixel words, %0d of them repeated runs.",
			words_checked, runs_checked);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
